// ----- design/epse_pkg.sv -----
// Package: payload types, SHA-256 constants and helper functions for the entropy pool.
`timescale 1ns / 1ps
package epse_pkg;

    localparam int unsigned POOL_DEPTH = 8;
    localparam int unsigned CHUNK_MAX  = 32;

    typedef struct packed {
        logic        req_type;
        logic [31:0] sample;
        logic [31:0] cycle_stamp;
        logic [7:0]  data_byte;
        logic        run_first;
        logic        run_last;
        logic [12:0] total_len;
    } epse_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       chunk_end;
        logic       extract_done;
    } epse_result_t;

    localparam logic REQ_STIR    = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Word m of the padded message: pool (LE words) || chunk || counter (LE) || pad || bit length
    function automatic logic [31:0] msg_word(
        input logic [4:0]  m,
        input logic [31:0] pw,
        input logic [31:0] cw,
        input logic [5:0]  c,
        input logic [7:0]  cnt8
    );
        logic [31:0] w;
        logic [7:0]  p;
        logic [7:0]  b;
        logic [7:0]  len;
        logic [15:0] bits;
        logic [7:0]  lastpos;
        len     = 8'd36 + {2'b00, c};
        bits    = {5'b0, len, 3'b000};
        lastpos = (c > 6'd19) ? 8'd127 : 8'd63;
        w       = '0;
        for (int k = 0; k < 4; k++)
        begin
            p = {1'b0, m, 2'(k)};
            if (p < 8'd32)
                b = pw[8*k +: 8];
            else if (p < 8'd32 + {2'b00, c})
                b = cw[8*(3-k) +: 8];
            else if (p == 8'd32 + {2'b00, c})
                b = cnt8;
            else if (p < len)
                b = 8'h00;
            else if (p == len)
                b = 8'h80;
            else if (p == lastpos - 8'd1)
                b = bits[15:8];
            else if (p == lastpos)
                b = bits[7:0];
            else
                b = 8'h00;
            w[8*(3-k) +: 8] = b;
        end
        return w;
    endfunction

endpackage

// ----- design/epse_item_if.sv -----
// Interface: input item channel with valid/ready handshake.
`timescale 1ns / 1ps
interface epse_item_if;
    import epse_pkg::*;
    logic       valid;
    logic       ready;
    epse_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/epse_result_if.sv -----
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface epse_result_if;
    import epse_pkg::*;
    logic         valid;
    logic         ready;
    epse_result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/entropy_pool_stir_and_extract.sv -----
// Top level: entropy pool with stir, SHA-256 whitened extract and ratchet.
`timescale 1ns / 1ps
// A stir item or a byte that does not close a chunk is taken in S_IDLE. A byte that closes
// a chunk starts the shared SHA-256 round unit, one round per cycle, with a feed-forward add after
// each block: one block for a chunk of up to 19 bytes, two for a longer one, and another block for
// the pool ratchet on the last chunk of a run. Then as many digest bytes as the chunk held leave
// one per transfer; no item is taken until the last one has gone.
module entropy_pool_stir_and_extract
    import epse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    epse_item_if.sink     item,
    epse_result_if.source result
);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_EMIT} state_t;

    state_t      state_reg;
    logic [31:0] pool_reg  [8];
    logic [2:0]  slot_reg;
    logic [31:0] chunk_reg [8];
    logic [5:0]  fill_reg;
    logic [7:0]  count_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  mlen_reg;
    logic        ratch_reg;
    logic        last_reg;
    logic        blk_reg;
    logic [5:0]  t_reg;
    logic [31:0] h_reg     [8];
    logic [31:0] v_reg     [8];
    logic [31:0] sh_reg    [16];
    logic [31:0] dig_reg   [8];
    logic [4:0]  idx_reg;

    logic [2:0]  pool_idx;
    logic [31:0] pool_rd;
    logic [31:0] stir_val;
    logic [31:0] stir_word;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] hsum      [8];
    logic [5:0]  fill_base;
    logic [5:0]  fill_next;
    logic        accept;
    logic        two_blocks;
    logic [31:0] dig_word;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign pool_idx   = (state_reg == S_IDLE) ? slot_reg : t_reg[2:0];
    assign pool_rd    = pool_reg[pool_idx];
    assign stir_val   = (item.data.req_type == REQ_STIR) ? item.data.sample
                                                         : {19'b0, item.data.total_len};
    assign stir_word  = {pool_rd[24:0], pool_rd[31:25]} ^ stir_val ^ item.data.cycle_stamp;
    assign fill_base  = item.data.run_first ? 6'd0 : fill_reg;
    assign fill_next  = fill_base + 6'd1;
    assign two_blocks = (mlen_reg > 6'd19);

    always_comb
    begin
        if (t_reg < 6'd16)
            w_cur = msg_word({blk_reg, t_reg[3:0]}, pool_rd, chunk_reg[t_reg[2:0]],
                             mlen_reg, count_reg);
        else
            w_cur = (rotr(sh_reg[14], 17) ^ rotr(sh_reg[14], 19) ^ (sh_reg[14] >> 10))
                  + sh_reg[9]
                  + (rotr(sh_reg[1], 7) ^ rotr(sh_reg[1], 18) ^ (sh_reg[1] >> 3))
                  + sh_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(t_reg) + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        for (int i = 0; i < 8; i++)
        begin
            hsum[i] = h_reg[i] + v_reg[i];
        end
    end

    assign dig_word                 = dig_reg[idx_reg[4:2]];
    assign result.valid             = (state_reg == S_EMIT);
    assign result.data.out_byte     = dig_word[8*(3 - idx_reg[1:0]) +: 8];
    assign result.data.chunk_end    = ({1'b0, idx_reg} == cnt_reg - 6'd1);
    assign result.data.extract_done = last_reg && result.data.chunk_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            cnt_reg   <= '0;
            mlen_reg  <= '0;
            ratch_reg <= 1'b0;
            last_reg  <= 1'b0;
            blk_reg   <= 1'b0;
            t_reg     <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                pool_reg[i]  <= '0;
                chunk_reg[i] <= '0;
                h_reg[i]     <= '0;
                v_reg[i]     <= '0;
                dig_reg[i]   <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                sh_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.data.req_type == REQ_STIR || item.data.run_first)
                        begin
                            pool_reg[slot_reg] <= stir_word;
                            slot_reg           <= slot_reg + 3'd1;
                        end
                        if (item.data.req_type == REQ_EXTRACT)
                        begin
                            if (item.data.run_first)
                                count_reg <= '0;
                            chunk_reg[fill_base[4:2]][8*(3 - fill_base[1:0]) +: 8]
                                <= item.data.data_byte;
                            fill_reg <= fill_next;
                            if (fill_next == 6'(CHUNK_MAX) || item.data.run_last)
                            begin
                                cnt_reg   <= fill_next;
                                mlen_reg  <= fill_next;
                                ratch_reg <= 1'b0;
                                last_reg  <= item.data.run_last;
                                blk_reg   <= 1'b0;
                                t_reg     <= '0;
                                h_reg     <= START_H;
                                v_reg     <= START_H;
                                state_reg <= S_ROUND;
                            end
                        end
                    end
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        sh_reg[i] <= sh_reg[i+1];
                    end
                    sh_reg[15] <= w_cur;
                    t_reg      <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    t_reg <= '0;
                    if (!blk_reg && two_blocks)
                    begin
                        blk_reg   <= 1'b1;
                        h_reg     <= hsum;
                        v_reg     <= hsum;
                        state_reg <= S_ROUND;
                    end
                    else if (!ratch_reg)
                    begin
                        dig_reg   <= hsum;
                        count_reg <= count_reg + 8'd1;
                        fill_reg  <= '0;
                        idx_reg   <= '0;
                        if (last_reg)
                        begin
                            ratch_reg <= 1'b1;
                            mlen_reg  <= '0;
                            blk_reg   <= 1'b0;
                            h_reg     <= START_H;
                            v_reg     <= START_H;
                            state_reg <= S_ROUND;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            pool_reg[i] <= bswap(hsum[i]);
                        end
                        count_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (result.ready)
                    begin
                        if (result.data.chunk_end)
                            state_reg <= S_IDLE;
                        else
                            idx_reg <= idx_reg + 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !result.valid)
        else $error("item taken while results pending");

    a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.extract_done) |-> result.data.chunk_end)
        else $error("run end without chunk end");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && t_reg == 6'd63) |=> (state_reg == S_ADD))
        else $error("round count overrun");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("emit index beyond chunk");

endmodule
